### sv/nnsc_pkg.sv
// Shared types and constants for the nearest-neighbor scale address generator.
package nnsc_pkg;

   localparam int DIM_W      = 12;
   localparam int LVL_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int BASE_W     = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_CNT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_BASE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_BASE   = 3'd6;

   typedef enum logic [2:0] {
      ST_POP,
      ST_DX,
      ST_DXW,
      ST_DY,
      ST_DYW,
      ST_MUL,
      ST_SUM
   } back_state_type;

   typedef struct packed {
      logic valid;
      logic restart;
   } queue_head_type;

   function automatic logic [DIM_W-1:0] halve(input logic [DIM_W-1:0] v);
      halve = (v > DIM_W'(1)) ? (v >> 1) : v;
   endfunction

endpackage

### sv/nnsc_if.sv
// Request and response channel interfaces.
interface nnsc_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface nnsc_rsp_if #(parameter int ADDR_BITS = 24);
   logic                 valid;
   logic                 ready;
   logic                 valid_res;
   logic [ADDR_BITS-1:0] src_addr;
   logic [ADDR_BITS-1:0] dst_addr;
   logic [3:0]           mip_level;
   logic                 level_end;
   logic                 job_end;
   modport source (output valid, output valid_res, output src_addr, output dst_addr,
                   output mip_level, output level_end, output job_end, input ready);
   modport sink (input valid, input valid_res, input src_addr, input dst_addr,
                 input mip_level, input level_end, input job_end, output ready);
endinterface

### sv/nn_scale_mip_address_gen.sv
// Top level of the nearest-neighbor scale and mip chain address generator.
// Usage:
//  req_chan carries one request per item: restart=1 starts the job at level 0
//  pixel 0, restart=0 steps to the next destination pixel. Each request gives
//  exactly one response on rsp_chan: a source/destination address pair with
//  its mip level and level/job end flags, or valid_res=0 with zero fields when
//  no job is running. csr_* writes the dimension, level count and base
//  registers; write them only while no request is outstanding.
//  A plain pixel step passes the queue, the multiply state and the address
//  sum state before its response is registered; a request with no job
//  running is answered straight from the pop. A restart or level change
//  first runs two 12-bit quotient/remainder divisions on the shared serial divider.
//  Requests are worked one at a time; a two-entry request queue and the
//  response register let the requester keep going while a response waits.
//  Reset: registers return to dimensions 1, one level, bases 0, and the block
//  reports no job until a restart. A stalled rsp_chan holds the response and
//  stops the walker; the queue then fills and req_chan ready drops.
module nn_scale_mip_address_gen #(
   parameter int MAX_DIM    = 2048,
   parameter int ADDR_BITS  = 24,
   parameter int MAX_LEVELS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   nnsc_req_if.sink                        req_chan,
   nnsc_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [nnsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nnsc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import nnsc_pkg::*;

   queue_head_type head;
   logic           pop;

   nnsc_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .pop   (pop),
      .head  (head)
   );

   nnsc_back #(
      .MAX_DIM    (MAX_DIM),
      .ADDR_BITS  (ADDR_BITS),
      .MAX_LEVELS (MAX_LEVELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .head      (head),
      .pop       (pop),
      .rsp       (rsp_chan)
   );
endmodule

### sv/nnsc_front.sv
// Request intake: two-entry queue of requests ahead of the generator.
module nnsc_front (
   input  logic                    clock,
   input  logic                    reset,
   nnsc_req_if.sink                req,
   input  logic                    pop,
   output nnsc_pkg::queue_head_type head
);
   import nnsc_pkg::*;

   logic [1:0] vld_ff, vld_in;
   logic [1:0] rst_ff, rst_in;
   logic       push;

   assign req.ready = ~vld_ff[1];
   assign push      = req.valid & req.ready;
   assign head.valid   = vld_ff[0];
   assign head.restart = rst_ff[0];

   always_comb begin
      vld_in = vld_ff;
      rst_in = rst_ff;
      if (pop) begin
         vld_in = {1'b0, vld_ff[1]};
         rst_in = {1'b0, rst_ff[1]};
      end
      if (push) begin
         if (!vld_in[0]) begin
            vld_in[0] = 1'b1;
            rst_in[0] = req.restart;
         end else begin
            vld_in[1] = 1'b1;
            rst_in[1] = req.restart;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      rst_ff <= rst_in;
   end
endmodule

### sv/nnsc_div.sv
// Restoring divider, one quotient bit per cycle.
module nnsc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [nnsc_pkg::DIM_W-1:0] dividend,
   input  logic [nnsc_pkg::DIM_W-1:0] divisor,
   output logic                       busy,
   output logic [nnsc_pkg::DIM_W-1:0] quotient,
   output logic [nnsc_pkg::DIM_W-1:0] remainder
);
   import nnsc_pkg::*;

   localparam int CNT_W = $clog2(DIM_W + 1);

   logic [DIM_W:0]   rem_ff, rem_in;
   logic [DIM_W-1:0] quo_ff, quo_in;
   logic [DIM_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIM_W:0]   trial;

   assign busy      = cnt_ff != '0;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[DIM_W-1:0];
   assign trial     = {rem_ff[DIM_W-1:0], quo_ff[DIM_W-1]};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = CNT_W'(DIM_W);
      end else if (busy) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[DIM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end
endmodule

### sv/nnsc_back.sv
// Address walker: position stepping, level setup and response register.
module nnsc_back #(
   parameter int MAX_DIM    = 2048,
   parameter int ADDR_BITS  = 24,
   parameter int MAX_LEVELS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [nnsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nnsc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  nnsc_pkg::queue_head_type        head,
   output logic                            pop,
   nnsc_rsp_if.source                      rsp
);
   import nnsc_pkg::*;

   typedef logic [DIM_W-1:0]     dim_type;
   typedef logic [ADDR_BITS-1:0] addr_type;

   dim_type           cfg_sw_ff, cfg_sh_ff, cfg_dw_ff, cfg_dh_ff;
   logic [LVL_W-1:0]  cfg_lc_ff;
   logic [BASE_W-1:0] cfg_sb_ff, cfg_db_ff;

   back_state_type state_ff, state_in;
   dim_type    sw_ff, sh_ff, dw_ff, dh_ff;
   dim_type    qx_ff, rx_ff, qy_ff, ry_ff;
   dim_type    dcol_ff, drow_ff, scol_ff, srow_ff, crem_ff, rrem_ff;
   logic [LVL_W-1:0] lvl_ff;
   addr_type   soff_ff, doff_ff;
   logic       fin_ff;
   logic [2*DIM_W-1:0] sprod_ff, dprod_ff;
   logic       lend_ff, jend_ff;

   logic       out_vld_ff;
   logic       out_res_ff;
   addr_type   out_sa_ff, out_da_ff;
   logic [LVL_W-1:0] out_lvl_ff;
   logic       out_lend_ff, out_jend_ff;

   logic       out_free, take;
   logic       div_start, div_busy;
   dim_type    div_a, div_b, div_q, div_r;
   logic       col_last, row_last, lvl_end, job_end;
   logic [LVL_W-1:0] eff_lvls;
   logic [DIM_W:0]   crem_sum, rrem_sum;

   function automatic dim_type clamp_dim(input dim_type v);
      if (v == '0) begin
         clamp_dim = DIM_W'(1);
      end else if (32'(v) > 32'(MAX_DIM)) begin
         clamp_dim = DIM_W'(MAX_DIM);
      end else begin
         clamp_dim = v;
      end
   endfunction

   nnsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .busy      (div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign out_free = ~out_vld_ff | rsp.ready;
   assign take     = (state_ff == ST_POP) & head.valid & out_free;
   assign pop      = take;

   always_comb begin
      if (cfg_lc_ff == '0) begin
         eff_lvls = LVL_W'(1);
      end else if (32'(cfg_lc_ff) > 32'(MAX_LEVELS)) begin
         eff_lvls = LVL_W'(MAX_LEVELS);
      end else begin
         eff_lvls = cfg_lc_ff;
      end
   end

   assign col_last = ({1'b0, dcol_ff} + (DIM_W+1)'(1)) >= {1'b0, dw_ff};
   assign row_last = ({1'b0, drow_ff} + (DIM_W+1)'(1)) >= {1'b0, dh_ff};
   assign lvl_end  = col_last & row_last;
   assign job_end  = lvl_end & (({1'b0, lvl_ff} + (LVL_W+1)'(1)) >= {1'b0, eff_lvls});
   assign crem_sum = {1'b0, crem_ff} + {1'b0, rx_ff};
   assign rrem_sum = {1'b0, rrem_ff} + {1'b0, ry_ff};

   assign div_start = (state_ff == ST_DX) | (state_ff == ST_DY);
   assign div_a     = (state_ff == ST_DX) ? sw_ff : sh_ff;
   assign div_b     = (state_ff == ST_DX) ? dw_ff : dh_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_POP: begin
            if (take) begin
               if (head.restart) begin
                  state_in = ST_DX;
               end else if (fin_ff || job_end) begin
                  state_in = ST_POP;
               end else if (col_last && row_last) begin
                  state_in = ST_DX;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_DX:  state_in = ST_DXW;
         ST_DXW: if (!div_busy) state_in = ST_DY;
         ST_DY:  state_in = ST_DYW;
         ST_DYW: if (!div_busy) state_in = ST_MUL;
         ST_MUL: state_in = ST_SUM;
         ST_SUM: state_in = ST_POP;
         default: state_in = ST_POP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_POP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_sw_ff <= DIM_W'(1);
         cfg_sh_ff <= DIM_W'(1);
         cfg_dw_ff <= DIM_W'(1);
         cfg_dh_ff <= DIM_W'(1);
         cfg_lc_ff <= LVL_W'(1);
         cfg_sb_ff <= '0;
         cfg_db_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SRC_WIDTH:  cfg_sw_ff <= csr_wdata[DIM_W-1:0];
            CSR_SRC_HEIGHT: cfg_sh_ff <= csr_wdata[DIM_W-1:0];
            CSR_DST_WIDTH:  cfg_dw_ff <= csr_wdata[DIM_W-1:0];
            CSR_DST_HEIGHT: cfg_dh_ff <= csr_wdata[DIM_W-1:0];
            CSR_LEVEL_CNT:  cfg_lc_ff <= csr_wdata[LVL_W-1:0];
            CSR_SRC_BASE:   cfg_sb_ff <= csr_wdata[BASE_W-1:0];
            CSR_DST_BASE:   cfg_db_ff <= csr_wdata[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff     <= 1'b1;
         out_vld_ff <= 1'b0;
         lvl_ff     <= '0;
      end else begin
         if (out_vld_ff && rsp.ready) begin
            out_vld_ff <= 1'b0;
         end
         case (state_ff)
            ST_POP: begin
               if (take) begin
                  if (head.restart) begin
                     sw_ff   <= clamp_dim(cfg_sw_ff);
                     sh_ff   <= clamp_dim(cfg_sh_ff);
                     dw_ff   <= clamp_dim(cfg_dw_ff);
                     dh_ff   <= clamp_dim(cfg_dh_ff);
                     lvl_ff  <= '0;
                     dcol_ff <= '0;
                     drow_ff <= '0;
                     scol_ff <= '0;
                     srow_ff <= '0;
                     crem_ff <= '0;
                     rrem_ff <= '0;
                     soff_ff <= '0;
                     doff_ff <= '0;
                     fin_ff  <= 1'b0;
                  end else if (fin_ff || job_end) begin
                     fin_ff      <= 1'b1;
                     out_vld_ff  <= 1'b1;
                     out_res_ff  <= 1'b0;
                     out_sa_ff   <= '0;
                     out_da_ff   <= '0;
                     out_lvl_ff  <= '0;
                     out_lend_ff <= 1'b0;
                     out_jend_ff <= 1'b0;
                  end else if (!col_last) begin
                     dcol_ff <= dcol_ff + DIM_W'(1);
                     if (crem_sum >= {1'b0, dw_ff}) begin
                        crem_ff <= DIM_W'(crem_sum - {1'b0, dw_ff});
                        scol_ff <= scol_ff + qx_ff + DIM_W'(1);
                     end else begin
                        crem_ff <= crem_sum[DIM_W-1:0];
                        scol_ff <= scol_ff + qx_ff;
                     end
                  end else if (!row_last) begin
                     dcol_ff <= '0;
                     scol_ff <= '0;
                     crem_ff <= '0;
                     drow_ff <= drow_ff + DIM_W'(1);
                     if (rrem_sum >= {1'b0, dh_ff}) begin
                        rrem_ff <= DIM_W'(rrem_sum - {1'b0, dh_ff});
                        srow_ff <= srow_ff + qy_ff + DIM_W'(1);
                     end else begin
                        rrem_ff <= rrem_sum[DIM_W-1:0];
                        srow_ff <= srow_ff + qy_ff;
                     end
                  end else begin
                     soff_ff <= soff_ff + ADDR_BITS'({{DIM_W{1'b0}}, sw_ff}
                                                     * {{DIM_W{1'b0}}, sh_ff});
                     doff_ff <= doff_ff + ADDR_BITS'({{DIM_W{1'b0}}, dw_ff}
                                                     * {{DIM_W{1'b0}}, dh_ff});
                     sw_ff   <= halve(sw_ff);
                     sh_ff   <= halve(sh_ff);
                     dw_ff   <= halve(dw_ff);
                     dh_ff   <= halve(dh_ff);
                     lvl_ff  <= lvl_ff + LVL_W'(1);
                     dcol_ff <= '0;
                     drow_ff <= '0;
                     scol_ff <= '0;
                     srow_ff <= '0;
                     crem_ff <= '0;
                     rrem_ff <= '0;
                  end
               end
            end
            ST_DXW: begin
               if (!div_busy) begin
                  qx_ff <= div_q;
                  rx_ff <= div_r;
               end
            end
            ST_DYW: begin
               if (!div_busy) begin
                  qy_ff <= div_q;
                  ry_ff <= div_r;
               end
            end
            ST_MUL: begin
               sprod_ff <= srow_ff * sw_ff;
               dprod_ff <= drow_ff * dw_ff;
               lend_ff  <= lvl_end;
               jend_ff  <= job_end;
            end
            ST_SUM: begin
               out_vld_ff  <= 1'b1;
               out_res_ff  <= 1'b1;
               out_sa_ff   <= ADDR_BITS'(cfg_sb_ff) + soff_ff + ADDR_BITS'(sprod_ff)
                              + ADDR_BITS'(scol_ff);
               out_da_ff   <= ADDR_BITS'(cfg_db_ff) + doff_ff + ADDR_BITS'(dprod_ff)
                              + ADDR_BITS'(dcol_ff);
               out_lvl_ff  <= lvl_ff;
               out_lend_ff <= lend_ff;
               out_jend_ff <= jend_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid     = out_vld_ff;
   assign rsp.valid_res = out_res_ff;
   assign rsp.src_addr  = out_sa_ff;
   assign rsp.dst_addr  = out_da_ff;
   assign rsp.mip_level = out_lvl_ff;
   assign rsp.level_end = out_lend_ff;
   assign rsp.job_end   = out_jend_ff;
endmodule

### bench/nn_scale_mip_address_gen_checker.sv
// Checker: predicts each address pair from the requests and compares the responses.
`timescale 1ns / 1ps
module nn_scale_mip_address_gen_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_restart,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_valid_res,
   input  logic [23:0]                     rsp_src_addr,
   input  logic [23:0]                     rsp_dst_addr,
   input  logic [3:0]                      rsp_mip_level,
   input  logic                            rsp_level_end,
   input  logic                            rsp_job_end,
   input  logic                            csr_we,
   input  logic [nnsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nnsc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              errors,
   output int                              pending
);
   import nnsc_pkg::*;

   localparam int MAX_DIM = 2048;
   localparam int MAX_LVL = 12;

   typedef struct packed {
      logic        valid_res;
      logic [23:0] src_addr;
      logic [23:0] dst_addr;
      logic [3:0]  mip_level;
      logic        level_end;
      logic        job_end;
   } addr_pair_type;

   addr_pair_type pair_q[$];

   logic [11:0] reg_dim[4];
   logic [3:0]  reg_levels;
   logic [23:0] reg_src_base, reg_dst_base;

   int unsigned lvl_dim[4], lvl_step[4];
   int unsigned level, dcol, drow, scol, srow, col_rem, row_rem;
   logic [23:0] src_off, dst_off;
   bit          done;

   assign pending = pair_q.size();

   function automatic int unsigned clamp_dim(logic [11:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   function automatic int unsigned live_levels();
      if (reg_levels == 0) return 1;
      if (reg_levels > MAX_LVL) return MAX_LVL;
      return reg_levels;
   endfunction

   function automatic bit last_in_level();
      return dcol + 1 >= lvl_dim[2] && drow + 1 >= lvl_dim[3];
   endfunction

   function automatic bit last_in_job();
      return last_in_level() && level + 1 >= live_levels();
   endfunction

   function automatic void load_steps();
      lvl_step[0] = lvl_dim[0] / lvl_dim[2];
      lvl_step[1] = lvl_dim[0] % lvl_dim[2];
      lvl_step[2] = lvl_dim[1] / lvl_dim[3];
      lvl_step[3] = lvl_dim[1] % lvl_dim[3];
   endfunction

   function automatic void clear_walk();
      dcol = 0; drow = 0; scol = 0; srow = 0; col_rem = 0; row_rem = 0;
   endfunction

   function automatic void step_pixel();
      if (dcol + 1 < lvl_dim[2]) begin
         dcol++;
         scol += lvl_step[0];
         col_rem += lvl_step[1];
         if (col_rem >= lvl_dim[2]) begin
            col_rem -= lvl_dim[2];
            scol++;
         end
         return;
      end
      dcol = 0; scol = 0; col_rem = 0;
      if (drow + 1 < lvl_dim[3]) begin
         drow++;
         srow += lvl_step[2];
         row_rem += lvl_step[3];
         if (row_rem >= lvl_dim[3]) begin
            row_rem -= lvl_dim[3];
            srow++;
         end
         return;
      end
      src_off = src_off + 24'(lvl_dim[0] * lvl_dim[1]);
      dst_off = dst_off + 24'(lvl_dim[2] * lvl_dim[3]);
      for (int i = 0; i < 4; i++)
         lvl_dim[i] = (lvl_dim[i] > 1) ? (lvl_dim[i] >> 1) : lvl_dim[i];
      load_steps();
      level++;
      clear_walk();
   endfunction

   function automatic addr_pair_type current_pair();
      addr_pair_type p;
      p.valid_res = 1'b1;
      p.src_addr  = reg_src_base + src_off + 24'(srow * lvl_dim[0] + scol);
      p.dst_addr  = reg_dst_base + dst_off + 24'(drow * lvl_dim[2] + dcol);
      p.mip_level = level[3:0];
      p.level_end = last_in_level();
      p.job_end   = last_in_job();
      return p;
   endfunction

   function automatic addr_pair_type predict_pair(logic restart);
      if (restart) begin
         for (int i = 0; i < 4; i++) lvl_dim[i] = clamp_dim(reg_dim[i]);
         load_steps();
         level = 0;
         clear_walk();
         src_off = '0;
         dst_off = '0;
         done = 1'b0;
         return current_pair();
      end
      if (!done) begin
         if (last_in_job()) begin
            done = 1'b1;
         end else begin
            step_pixel();
            return current_pair();
         end
      end
      return '0;
   endfunction

   always @(posedge clock) begin
      addr_pair_type got, want;
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            reg_dim[i] = 12'd1;
            lvl_dim[i] = 0;
            lvl_step[i] = 0;
         end
         reg_levels = 4'd1;
         reg_src_base = '0;
         reg_dst_base = '0;
         level = 0;
         clear_walk();
         src_off = '0;
         dst_off = '0;
         done = 1'b1;
         pair_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SRC_WIDTH:  reg_dim[0] = csr_wdata[11:0];
               CSR_SRC_HEIGHT: reg_dim[1] = csr_wdata[11:0];
               CSR_DST_WIDTH:  reg_dim[2] = csr_wdata[11:0];
               CSR_DST_HEIGHT: reg_dim[3] = csr_wdata[11:0];
               CSR_LEVEL_CNT:  reg_levels = csr_wdata[3:0];
               CSR_SRC_BASE:   reg_src_base = csr_wdata;
               CSR_DST_BASE:   reg_dst_base = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pair_q.push_back(predict_pair(req_restart));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_valid_res, rsp_src_addr, rsp_dst_addr, rsp_mip_level,
                   rsp_level_end, rsp_job_end};
            if (pair_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected response: %p", $time, got);
            end else begin
               want = pair_q.pop_front();
               if (got.valid_res != want.valid_res || got.src_addr != want.src_addr ||
                   got.dst_addr != want.dst_addr || got.mip_level != want.mip_level ||
                   got.level_end != want.level_end || got.job_end != want.job_end) begin
                  errors++;
                  $display("%0t: mismatch expected %p", $time, want);
                  $display("%0t:          actual   %p", $time, got);
               end
            end
         end
      end
   end

   initial errors = 0;

endmodule

### bench/nn_scale_mip_address_gen_test.sv
// Top of the address generator bench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps
module nn_scale_mip_address_gen_test;
   import nnsc_pkg::*;

   localparam int LIMIT = 3000000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int errors, pending, cycles, sent;
   bit hold_rsp;

   nnsc_req_if req_chan ();
   nnsc_rsp_if #(.ADDR_BITS(24)) rsp_chan ();

   nn_scale_mip_address_gen u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   nn_scale_mip_address_gen_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .req_restart(req_chan.restart),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .rsp_valid_res(rsp_chan.valid_res), .rsp_src_addr(rsp_chan.src_addr),
      .rsp_dst_addr(rsp_chan.dst_addr), .rsp_mip_level(rsp_chan.mip_level),
      .rsp_level_end(rsp_chan.level_end), .rsp_job_end(rsp_chan.job_end),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending)
   );

   always begin
      clock = 1'b0; #10;
      clock = 1'b1; #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // long receiver stall once the run is well under way
   initial begin
      hold_rsp = 1'b0;
      wait (sent >= 600);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // response side
   initial begin
      int g;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end else begin
            g = gap_len();
            rsp_chan.ready <= (g == 0);
            if (g > 0) repeat (g - 1) @(posedge clock);
         end
      end
   end

   bit calm;

   task automatic send_request(logic restart);
      int g;
      req_chan.valid <= 1'b1;
      req_chan.restart <= restart;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
      g = calm ? 0 : gap_len();
      if (g > 0) begin
         req_chan.valid <= 1'b0;
         req_chan.restart <= 1'($urandom_range(0, 1));
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_job(int sw, int sh, int dw, int dh, int lc, int sb, int db);
      write_reg(CSR_SRC_WIDTH, CSR_DATA_W'(sw));
      write_reg(CSR_SRC_HEIGHT, CSR_DATA_W'(sh));
      write_reg(CSR_DST_WIDTH, CSR_DATA_W'(dw));
      write_reg(CSR_DST_HEIGHT, CSR_DATA_W'(dh));
      write_reg(CSR_LEVEL_CNT, CSR_DATA_W'(lc));
      write_reg(CSR_SRC_BASE, CSR_DATA_W'(sb));
      write_reg(CSR_DST_BASE, CSR_DATA_W'(db));
   endtask

   task automatic walk(int n);
      repeat (n) send_request(1'b0);
   endtask

   function automatic int pick_dim();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 9);
      if (r < 90) return 0;
      if (r < 95) return $urandom_range(2000, 4095);
      return $urandom_range(10, 64);
   endfunction

   initial begin
      int n;
      sent = 0;
      calm = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.restart = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle after reset, one-pixel job, advances past job end
      walk(1);
      send_request(1'b1);
      walk(2);
      drain();

      // 2048x2048 into 1x1 over all levels, addresses wrap
      set_job(2048, 2048, 1, 1, 12, 24'hFFFFF0, 24'hFFFFFF);
      send_request(1'b1);
      walk(13);
      drain();

      // zero and oversized dimensions, zero and oversized level counts
      set_job(0, 4095, 4095, 0, 0, 24'h000000, 24'h800000);
      write_reg(CSR_UNUSED, 24'hFFFFFF);
      send_request(1'b1);
      walk(4);
      drain();
      set_job(3, 5, 7, 2, 15, 24'h123456, 24'hABCDEF);
      send_request(1'b1);
      walk(3);
      drain();

      // register changes while a job is open
      set_job(4, 4, 4, 4, 4, 24'h000100, 24'h000200);
      send_request(1'b1);
      walk(5);
      drain();
      set_job(9, 9, 3, 3, 1, 24'h000300, 24'h000400);
      walk(16);
      drain();

      while (sent < 1060) begin
         calm = ($urandom_range(0, 4) == 0);
         set_job(pick_dim(), pick_dim(), pick_dim(), pick_dim(),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4),
                 $urandom, $urandom);
         if ($urandom_range(0, 9) != 0) send_request(1'b1);
         n = $urandom_range(5, 90);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 49) == 0) send_request(1'b1);
            else send_request(1'b0);
         end
         drain();
      end

      drain();
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
